// ===== rtl/cdg_pkg.sv =====
// Shared types and constants for the call-depth and instruction-budget guard.
// Depends on nothing; every other file of the block but cdg_if imports it.
package cdg_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W       = ((DEPTH_W > 7) ? DEPTH_W : 7) + 1;
   localparam int CSR_AW      = 6;
   localparam int CSR_DW      = 64;

   typedef enum logic [1:0] {
      CMD_ENTER = 2'd0,
      CMD_EXIT  = 2'd1,
      CMD_INSTR = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_DEPTH  = 3'd1,
      KIND_METHOD = 3'd2,
      KIND_TOTAL  = 3'd3,
      KIND_COUNT  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_ENABLE       = 3'd0,
      REG_DEPTH_LIMIT  = 3'd1,
      REG_METHOD_LIMIT = 3'd2,
      REG_TOTAL_LIMIT  = 3'd3,
      REG_COUNT_LIMIT  = 3'd4,
      REG_HALT         = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic        guard_enable;
      logic [6:0]  depth_limit;
      logic [31:0] method_instr_limit;
      logic [47:0] total_instr_limit;
      logic [31:0] method_total_limit;
      logic        halt_on_limit;
   } cfg_type;

   // Decoded event handed from the depth stage to the check stage.
   typedef struct packed {
      cmd_type              cmd;
      logic [31:0]          pc;
      logic [15:0]          opcode;
      logic                 depth_fail;
      logic                 count_method;
      logic                 push;
      logic                 has_frame;
      logic [ADDR_W-1:0]    addr;
      logic [DEPTH_W-1:0]   depth_before;
      logic [DEPTH_W-1:0]   depth_after;
   } stage_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  violation_kind;
      logic        halt;
      logic [6:0]  depth;
      logic [31:0] violation_total;
      logic [47:0] offending_value;
      logic [47:0] limit_value;
      logic [31:0] violation_pc;
      logic [15:0] violation_opcode;
   } rsp_type;

endpackage

// ===== rtl/cdg_if.sv =====
// Valid/ready channel interfaces for the guard's event and result streams.
// Self-contained; used by the top level ports.
interface cdg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] pc;
   logic [15:0] opcode;

   modport source (output valid, command, pc, opcode, input ready);
   modport sink (input valid, command, pc, opcode, output ready);
endinterface

interface cdg_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  violation_kind;
   logic        halt;
   logic [6:0]  depth;
   logic [31:0] violation_total;
   logic [47:0] offending_value;
   logic [47:0] limit_value;
   logic [31:0] violation_pc;
   logic [15:0] violation_opcode;

   modport source (output valid, ok, violation_kind, halt, depth, violation_total,
                   offending_value, limit_value, violation_pc, violation_opcode,
                   input ready);
   modport sink (input valid, ok, violation_kind, halt, depth, violation_total,
                 offending_value, limit_value, violation_pc, violation_opcode,
                 output ready);
endinterface

// ===== rtl/cdg_csr.sv =====
// APB-style configuration registers of the guard.
// Depends on cdg_pkg for the register index codes and the config struct.
module cdg_csr import cdg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr;

   always_comb begin
      idx        = reg_idx_type'(csr_paddr[CSR_AW-1:3]);
      wr         = csr_psel && csr_penable && csr_pwrite;
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (idx)
         REG_ENABLE: begin
            csr_prdata = CSR_DW'(cfg_ff.guard_enable);
            if (wr) cfg_in.guard_enable = csr_pwdata[0];
         end
         REG_DEPTH_LIMIT: begin
            csr_prdata = CSR_DW'(cfg_ff.depth_limit);
            if (wr) cfg_in.depth_limit = csr_pwdata[6:0];
         end
         REG_METHOD_LIMIT: begin
            csr_prdata = CSR_DW'(cfg_ff.method_instr_limit);
            if (wr) cfg_in.method_instr_limit = csr_pwdata[31:0];
         end
         REG_TOTAL_LIMIT: begin
            csr_prdata = CSR_DW'(cfg_ff.total_instr_limit);
            if (wr) cfg_in.total_instr_limit = csr_pwdata[47:0];
         end
         REG_COUNT_LIMIT: begin
            csr_prdata = CSR_DW'(cfg_ff.method_total_limit);
            if (wr) cfg_in.method_total_limit = csr_pwdata[31:0];
         end
         REG_HALT: begin
            csr_prdata = CSR_DW'(cfg_ff.halt_on_limit);
            if (wr) cfg_in.halt_on_limit = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.guard_enable       <= 1'b1;
         cfg_ff.depth_limit        <= 7'(STACK_DEPTH);
         cfg_ff.method_instr_limit <= '0;
         cfg_ff.total_instr_limit  <= '0;
         cfg_ff.method_total_limit <= '0;
         cfg_ff.halt_on_limit      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== rtl/cdg_frame_ram.sv =====
// Per-frame instruction count memory: one write port, one registered read port.
// A read that meets a write to the same entry returns the new data.
// Depends on cdg_pkg for the stack depth.
module cdg_frame_ram import cdg_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cdg_depth.sv =====
// Front stage: decodes an accepted event, keeps the call depth and issues the
// frame count read. Depends on cdg_pkg for the command codes and stage struct.
module cdg_depth import cdg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic              advance,
   input  logic [1:0]        command,
   input  logic [31:0]       pc,
   input  logic [15:0]       opcode,
   output logic              stage_valid,
   output stage_type         stage,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr
);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   stage_type          stage_ff, stage_in;
   logic               valid_ff, valid_in;
   cmd_type            cmd;
   logic               not_full;
   logic               below_limit;
   logic               has_depth;

   always_comb begin
      cmd         = cmd_type'(command);
      not_full    = depth_ff < DEPTH_W'(STACK_DEPTH);
      below_limit = CMP_W'(depth_ff) < CMP_W'(cfg.depth_limit);
      has_depth   = depth_ff != '0;

      stage_in.cmd          = cmd;
      stage_in.pc           = pc;
      stage_in.opcode       = opcode;
      stage_in.depth_fail   = 1'b0;
      stage_in.count_method = 1'b0;
      stage_in.push         = 1'b0;
      stage_in.has_frame    = 1'b0;
      stage_in.addr         = ADDR_W'(depth_ff);
      stage_in.depth_before = depth_ff;
      depth_in              = depth_ff;

      unique case (cmd)
         CMD_ENTER: begin
            if (!cfg.guard_enable || below_limit) begin
               stage_in.push         = not_full;
               stage_in.count_method = cfg.guard_enable;
               if (not_full) depth_in = depth_ff + 1'b1;
            end else begin
               stage_in.depth_fail = 1'b1;
            end
         end
         CMD_EXIT: begin
            if (has_depth) depth_in = depth_ff - 1'b1;
         end
         CMD_INSTR: begin
            stage_in.has_frame = has_depth;
            stage_in.addr      = ADDR_W'(depth_ff - 1'b1);
         end
         CMD_CLEAR: begin
            depth_in = '0;
         end
         default: begin
            depth_in = depth_ff;
         end
      endcase
      stage_in.depth_after = depth_in;

      if (accept)       valid_in = 1'b1;
      else if (advance) valid_in = 1'b0;
      else              valid_in = valid_ff;

      rd_en   = accept && stage_in.has_frame;
      rd_addr = stage_in.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) stage_ff <= stage_in;
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ===== rtl/cdg_check.sv =====
// Back stage: updates the frame count, session counters and violation record,
// checks the limits and holds the result register. Depends on cdg_pkg.
module cdg_check import cdg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              stage_valid,
   input  stage_type         stage,
   input  logic [31:0]       frame_q,
   input  logic              rsp_ready,
   output logic              advance,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [31:0]       wr_data,
   output logic              rsp_valid,
   output rsp_type           rsp
);

   logic [47:0] sess_instr_ff, sess_instr_in;
   logic [31:0] meth_cnt_ff, meth_cnt_in;
   logic [31:0] viol_cnt_ff, viol_cnt_in;
   logic [47:0] last_value_ff, last_value_in;
   logic [47:0] last_limit_ff, last_limit_in;
   logic [31:0] last_pc_ff, last_pc_in;
   logic [15:0] last_opc_ff, last_opc_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   kind_type    kind;
   logic [31:0] cur;
   logic [31:0] meth_inc;
   logic [47:0] instr_inc;
   logic [47:0] rec_value, rec_limit;
   logic [31:0] rec_pc;
   logic [15:0] rec_opcode;
   logic        wr_req;
   logic        clear;

   always_comb begin
      advance   = stage_valid && (!out_valid_ff || rsp_ready);
      cur       = stage.has_frame ? ((frame_q == '1) ? frame_q : frame_q + 1'b1) : '0;
      meth_inc  = (meth_cnt_ff == '1) ? meth_cnt_ff : meth_cnt_ff + 1'b1;
      instr_inc = (sess_instr_ff == '1) ? sess_instr_ff : sess_instr_ff + 1'b1;

      kind          = KIND_NONE;
      rec_value     = '0;
      rec_limit     = '0;
      rec_pc        = '0;
      rec_opcode    = '0;
      wr_req        = 1'b0;
      wr_data       = cur;
      clear         = 1'b0;
      sess_instr_in = sess_instr_ff;
      meth_cnt_in   = meth_cnt_ff;

      unique case (stage.cmd)
         CMD_ENTER: begin
            // zero the new frame so an instruction never sees stale counts
            if (stage.push) begin
               wr_req  = 1'b1;
               wr_data = '0;
            end
            if (stage.depth_fail) begin
               kind      = KIND_DEPTH;
               rec_value = 48'(stage.depth_before) + 48'd1;
               rec_limit = 48'(cfg.depth_limit);
            end else if (stage.count_method) begin
               meth_cnt_in = meth_inc;
               if ((cfg.method_total_limit != '0) && (meth_inc > cfg.method_total_limit)) begin
                  kind      = KIND_COUNT;
                  rec_value = 48'(meth_inc);
                  rec_limit = 48'(cfg.method_total_limit);
               end
            end
         end
         CMD_EXIT: begin
            wr_req = 1'b0;
         end
         CMD_INSTR: begin
            sess_instr_in = instr_inc;
            wr_req        = stage.has_frame;
            if (cfg.guard_enable) begin
               if ((cfg.method_instr_limit != '0) && (cur > cfg.method_instr_limit)) begin
                  kind       = KIND_METHOD;
                  rec_value  = 48'(cur);
                  rec_limit  = 48'(cfg.method_instr_limit);
                  rec_pc     = stage.pc;
                  rec_opcode = stage.opcode;
               end else if ((cfg.total_instr_limit != '0) &&
                            (instr_inc > cfg.total_instr_limit)) begin
                  kind       = KIND_TOTAL;
                  rec_value  = instr_inc;
                  rec_limit  = cfg.total_instr_limit;
                  rec_pc     = stage.pc;
                  rec_opcode = stage.opcode;
               end
            end
         end
         CMD_CLEAR: begin
            clear = 1'b1;
         end
         default: begin
            clear = 1'b0;
         end
      endcase

      viol_cnt_in   = viol_cnt_ff;
      last_value_in = last_value_ff;
      last_limit_in = last_limit_ff;
      last_pc_in    = last_pc_ff;
      last_opc_in   = last_opc_ff;
      if (kind != KIND_NONE) begin
         viol_cnt_in   = (viol_cnt_ff == '1) ? viol_cnt_ff : viol_cnt_ff + 1'b1;
         last_value_in = rec_value;
         last_limit_in = rec_limit;
         last_pc_in    = rec_pc;
         last_opc_in   = rec_opcode;
      end
      if (clear) begin
         sess_instr_in = '0;
         meth_cnt_in   = '0;
         viol_cnt_in   = '0;
         last_value_in = '0;
         last_limit_in = '0;
         last_pc_in    = '0;
         last_opc_in   = '0;
      end

      wr_en   = advance && wr_req;
      wr_addr = stage.addr;

      out_in.ok               = (kind == KIND_NONE);
      out_in.violation_kind   = kind;
      out_in.halt             = (kind != KIND_NONE) && cfg.halt_on_limit;
      out_in.depth            = 7'(stage.depth_after);
      out_in.violation_total  = viol_cnt_in;
      out_in.offending_value  = last_value_in;
      out_in.limit_value      = last_limit_in;
      out_in.violation_pc     = last_pc_in;
      out_in.violation_opcode = last_opc_in;

      if (advance)        out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else                out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sess_instr_ff <= '0;
         meth_cnt_ff   <= '0;
         viol_cnt_ff   <= '0;
         last_value_ff <= '0;
         last_limit_ff <= '0;
         last_pc_ff    <= '0;
         last_opc_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            sess_instr_ff <= sess_instr_in;
            meth_cnt_ff   <= meth_cnt_in;
            viol_cnt_ff   <= viol_cnt_in;
            last_value_ff <= last_value_in;
            last_limit_ff <= last_limit_in;
            last_pc_ff    <= last_pc_in;
            last_opc_ff   <= last_opc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

// ===== rtl/call_depth_instruction_budget_guard.sv =====
// Call-depth and instruction-budget guard. It takes one interpreter event per
// cycle (enter, exit, instruction, clear) and returns one result per event, so
// a steady stream runs at one transfer per clock with no stall of its own. An
// event's result passes through the front-stage register and then the output
// register before it can transfer. While a result waits, the input side takes
// one more event into the back stage and then holds off until the waiting
// result transfers. The per-method instruction counts live in a frame memory
// with a registered read port; the front stage reads the top frame, the back
// stage increments it and writes it back, and a bypass in the memory read
// covers back-to-back instructions in the same frame. Frames are zeroed when
// entered, so no clearing pass runs after reset. Configuration sits on an
// APB-style port with 64-bit data, register i at byte address 8*i; write it
// only while no event is in flight.
// Depends on cdg_pkg, cdg_if, cdg_csr, cdg_frame_ram, cdg_depth and cdg_check.
module call_depth_instruction_budget_guard import cdg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   cdg_req_if.sink           req_chan,
   cdg_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type           cfg;
   stage_type         stage;
   rsp_type           rsp;
   logic              stage_valid;
   logic              advance;
   logic              accept;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       wr_data;
   logic [31:0]       frame_q;
   logic              rsp_valid;

   // Take a new event whenever the back stage is empty or moves on this cycle.
   assign req_chan.ready = !stage_valid || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   cdg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Front stage: call depth, enter/exit decisions, frame read.
   cdg_depth u_depth (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .advance     (advance),
      .command     (req_chan.command),
      .pc          (req_chan.pc),
      .opcode      (req_chan.opcode),
      .stage_valid (stage_valid),
      .stage       (stage),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   cdg_frame_ram u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (frame_q)
   );

   // Back stage: frame write-back, limit checks, result register.
   cdg_check u_check (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage       (stage),
      .frame_q     (frame_q),
      .rsp_ready   (rsp_chan.ready),
      .advance     (advance),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.ok               = rsp.ok;
   assign rsp_chan.violation_kind   = rsp.violation_kind;
   assign rsp_chan.halt             = rsp.halt;
   assign rsp_chan.depth            = rsp.depth;
   assign rsp_chan.violation_total  = rsp.violation_total;
   assign rsp_chan.offending_value  = rsp.offending_value;
   assign rsp_chan.limit_value      = rsp.limit_value;
   assign rsp_chan.violation_pc     = rsp.violation_pc;
   assign rsp_chan.violation_opcode = rsp.violation_opcode;

endmodule
